@@ rtl/core/nc2d_pkg.sv @@
// Shared constants and types for the nearest centroid search block.
package nc2d_pkg;

  localparam int TableDepth = 256;
  localparam int AddrW      = $clog2(TableDepth);
  localparam int CountW     = $clog2(TableDepth + 1);
  localparam int ConfigW    = 9;
  localparam int CoordW     = 32;
  localparam int IdW        = 31;
  localparam int DiffW      = CoordW;
  localparam int SqW        = 2 * DiffW;
  localparam int DistW      = SqW + 1;

  localparam logic OpWrite = 1'b0;
  localparam logic OpQuery = 1'b1;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic        [IdW-1:0]    id;
  } entry_t;

  // Marks one table read as it moves down the distance pipeline.
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } tag_t;

  typedef struct packed {
    logic           valid;
    logic [IdW-1:0] id;
  } res_t;

endpackage

@@ rtl/core/nc2d_table.sv @@
// Centroid table memory: one write port, one read port with registered data.
module nc2d_table (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [nc2d_pkg::AddrW-1:0] waddr_i,
  input  nc2d_pkg::entry_t        wdata_i,
  input  logic                    re_i,
  input  logic [nc2d_pkg::AddrW-1:0] raddr_i,
  output nc2d_pkg::entry_t        rdata_o
);
  import nc2d_pkg::*;

  entry_t mem_q [TableDepth];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/nc2d_dist.sv @@
// Squared distance pipeline: absolute differences, squares, sum.
module nc2d_dist (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  nc2d_pkg::tag_t                  tag_i,
  input  nc2d_pkg::entry_t                entry_i,
  input  logic signed [nc2d_pkg::CoordW-1:0] qx_i,
  input  logic signed [nc2d_pkg::CoordW-1:0] qy_i,
  output nc2d_pkg::tag_t                  tag_o,
  output logic [nc2d_pkg::DistW-1:0]      dist_o,
  output logic [nc2d_pkg::IdW-1:0]        id_o
);
  import nc2d_pkg::*;

  logic signed [CoordW:0] diff_x, diff_y;
  logic [DiffW-1:0]       abs_x_d, abs_y_d;

  tag_t             tag_a_q, tag_b_q, tag_c_q;
  logic [DiffW-1:0] abs_x_q, abs_y_q;
  logic [SqW-1:0]   sq_x_q, sq_y_q;
  logic [DistW-1:0] sum_q;
  logic [IdW-1:0]   id_a_q, id_b_q, id_c_q;

  // The difference of two 32-bit signed values has a magnitude below 2^32.
  always_comb begin
    diff_x  = (CoordW+1)'(qx_i) - (CoordW+1)'(entry_i.x);
    diff_y  = (CoordW+1)'(qy_i) - (CoordW+1)'(entry_i.y);
    abs_x_d = diff_x[CoordW] ? DiffW'(-diff_x) : DiffW'(diff_x);
    abs_y_d = diff_y[CoordW] ? DiffW'(-diff_y) : DiffW'(diff_y);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_a_q <= '0;
      tag_b_q <= '0;
      tag_c_q <= '0;
    end else begin
      tag_a_q <= tag_i;
      tag_b_q <= tag_a_q;
      tag_c_q <= tag_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    abs_x_q <= abs_x_d;
    abs_y_q <= abs_y_d;
    id_a_q  <= entry_i.id;
    sq_x_q  <= SqW'(abs_x_q) * SqW'(abs_x_q);
    sq_y_q  <= SqW'(abs_y_q) * SqW'(abs_y_q);
    id_b_q  <= id_a_q;
    sum_q   <= DistW'(sq_x_q) + DistW'(sq_y_q);
    id_c_q  <= id_b_q;
  end

  assign tag_o  = tag_c_q;
  assign dist_o = sum_q;
  assign id_o   = id_c_q;

endmodule

@@ rtl/core/nc2d_best.sv @@
// Running minimum over the scanned distances; lowest index wins ties.
module nc2d_best (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  nc2d_pkg::tag_t             tag_i,
  input  logic [nc2d_pkg::DistW-1:0] dist_i,
  input  logic [nc2d_pkg::IdW-1:0]   id_i,
  output nc2d_pkg::res_t             res_o
);
  import nc2d_pkg::*;

  logic [DistW-1:0] best_dist_q;
  logic [IdW-1:0]   best_id_q;
  logic             res_valid_q;
  logic [IdW-1:0]   res_id_q;
  logic             take;

  // Strictly smaller only, so an earlier entry keeps a tie.
  assign take = tag_i.valid && (tag_i.first || (dist_i < best_dist_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= tag_i.valid && tag_i.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      best_dist_q <= dist_i;
      best_id_q   <= id_i;
    end
    if (tag_i.valid && tag_i.last) begin
      res_id_q <= take ? id_i : best_id_q;
    end
  end

  assign res_o.valid = res_valid_q;
  assign res_o.id    = res_id_q;

endmodule

@@ rtl/core/nearest_centroid_search_2d.sv @@
// Top level of the nearest centroid search: control, scan counter, result port.
//
//   port group                 direction  when it moves
//   start/busy + op..cell_id   in         start high and busy low at a clock edge
//   cfg_we_i / cfg_wdata_i     in         cfg_we_i high at a clock edge
//   done_o + found_o, id       out        done_o high for one cycle, always taken
//
// A write leaves busy low, so the next item may follow. A query with N = min(entry_count,
// 256) > 0 scans one table entry per cycle from the read port of the table memory; done_o
// follows the last entry through the table read register, the distance pipeline and the
// result register, and busy drops at the edge that ends the done_o cycle. An empty search
// raises done_o in the cycle after the start edge. The receiver cannot stall the result
// transaction. Reset clears entry_count and the control flags; the table is not cleared.
module nearest_centroid_search_2d (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic                                op_i,
  input  logic [7:0]                          entry_index_i,
  input  logic signed [nc2d_pkg::CoordW-1:0]  point_x_i,
  input  logic signed [nc2d_pkg::CoordW-1:0]  point_y_i,
  input  logic [nc2d_pkg::IdW-1:0]            cell_id_i,
  input  logic                                cfg_we_i,
  input  logic [nc2d_pkg::ConfigW-1:0]        cfg_wdata_i,
  output logic                                done_o,
  output logic                                found_o,
  output logic [nc2d_pkg::IdW-1:0]            nearest_id_o
);
  import nc2d_pkg::*;

  logic [ConfigW-1:0]       entry_count_q;
  logic                     busy_q;
  logic                     scan_q;
  logic                     empty_q;
  logic [AddrW-1:0]         addr_q;
  logic [AddrW-1:0]         last_addr_q;
  logic signed [CoordW-1:0] qx_q, qy_q;
  tag_t                     tag_rd_q;

  logic             accept, write_acc, query_acc;
  logic [CountW-1:0] count;
  tag_t             tag_issue;
  entry_t           wr_entry, rd_entry;
  tag_t             dist_tag;
  logic [DistW-1:0] sq_dist;
  logic [IdW-1:0]   dist_id;
  res_t             best_res;

  assign accept    = start && !busy_q;
  assign write_acc = accept && (op_i == OpWrite);
  assign query_acc = accept && (op_i == OpQuery);

  // Counts past the table depth search the whole table.
  always_comb begin
    if (32'(entry_count_q) > 32'(TableDepth)) begin
      count = CountW'(TableDepth);
    end else begin
      count = CountW'(entry_count_q);
    end
  end

  always_comb begin
    tag_issue.valid = scan_q;
    tag_issue.first = (addr_q == '0);
    tag_issue.last  = (addr_q == last_addr_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= '0;
      busy_q        <= 1'b0;
      scan_q        <= 1'b0;
      empty_q       <= 1'b0;
      addr_q        <= '0;
      tag_rd_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        entry_count_q <= cfg_wdata_i;
      end
      tag_rd_q <= tag_issue;
      empty_q  <= query_acc && (count == '0);
      if (query_acc) begin
        busy_q <= 1'b1;
        scan_q <= (count != '0);
        addr_q <= '0;
      end else if (scan_q) begin
        addr_q <= addr_q + 1'b1;
        if (tag_issue.last) begin
          scan_q <= 1'b0;
        end
      end
      if (done_o) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Hold the query point and scan bound for the length of the scan.
  always_ff @(posedge clk_i) begin
    if (query_acc) begin
      qx_q        <= point_x_i;
      qy_q        <= point_y_i;
      last_addr_q <= AddrW'(count - 1'b1);
    end
  end

  assign wr_entry.x  = point_x_i;
  assign wr_entry.y  = point_y_i;
  assign wr_entry.id = cell_id_i;

  nc2d_table u_table (
    .clk_i   (clk_i),
    .we_i    (write_acc),
    .waddr_i (AddrW'(entry_index_i)),
    .wdata_i (wr_entry),
    .re_i    (scan_q),
    .raddr_i (addr_q),
    .rdata_o (rd_entry)
  );

  nc2d_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tag_i   (tag_rd_q),
    .entry_i (rd_entry),
    .qx_i    (qx_q),
    .qy_i    (qy_q),
    .tag_o   (dist_tag),
    .dist_o  (sq_dist),
    .id_o    (dist_id)
  );

  nc2d_best u_best (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tag_i  (dist_tag),
    .dist_i (sq_dist),
    .id_i   (dist_id),
    .res_o  (best_res)
  );

  assign busy         = busy_q;
  assign done_o       = best_res.valid || empty_q;
  assign found_o      = best_res.valid;
  assign nearest_id_o = best_res.valid ? best_res.id : '0;

  a_done_needs_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_q)
    else $error("result strobe without a pending query");

  a_scan_needs_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_q |-> busy_q)
    else $error("table scan outside a query");

  a_one_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(best_res.valid && empty_q))
    else $error("empty and scanned results collide");

  a_scan_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (query_acc && (count != '0)) |=> (scan_q && (addr_q == '0)))
    else $error("query did not start its scan at entry zero");

  a_done_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_q)
    else $error("busy held after the result transaction");

endmodule
